### design/dc_remove_smooth_clip_unit_assert.svh
// Assertion helpers shared by the block's modules.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef DC_REMOVE_SMOOTH_CLIP_UNIT_ASSERT_SVH
`define DC_REMOVE_SMOOTH_CLIP_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCRSC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCRSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dcrsc_pkg.sv
`default_nettype none

package dcrsc_pkg;

  localparam int WINDOW = 20480;

  localparam int SAMPLE_W = 8;
  localparam int STATE_W  = 25;
  localparam int FRAC_W   = 16;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int SUM_W    = STATE_W + 4;
  localparam int WHOLE_W  = STATE_W - FRAC_W;

  localparam int STATE_BOUND = 255 * (1 << FRAC_W);
  localparam int AUDIO_MAX   = 127;
  localparam int AUDIO_MIN   = -128;
  localparam int ROUND_HALF  = 4;

  localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 8'd128;

  // Window position and remainder of the running sum modulo WINDOW.
  localparam int CNT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int VSUM_W = ((CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W) + 1;

  // Exact reciprocal for the quotient of a narrow value by a small window.
  localparam int RECIP_S = VSUM_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
  localparam int RECIP_M = ((1 << RECIP_S) + WINDOW - 1) / WINDOW;
  localparam int PROD_W  = VSUM_W + RECIP_S + 2;

  typedef logic [SAMPLE_W-1:0]        sample_t;
  typedef logic signed [SAMPLE_W-1:0] audio_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic [CNT_W-1:0]           count_t;

  typedef struct packed {
    logic    en;
    sample_t sample;
  } step_t;

endpackage

`default_nettype wire

### design/dcrsc_offset_track.sv
`default_nettype none

`include "dc_remove_smooth_clip_unit_assert.svh"

module dcrsc_offset_track (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dcrsc_pkg::step_t step,
  output dcrsc_pkg::sample_t    dc_offset
);
  import dcrsc_pkg::*;

  // The running sum is kept as a quotient and a remainder modulo WINDOW.
  count_t            window_count;
  count_t            window_count_next;
  count_t            rem;
  count_t            rem_next;
  sample_t           quot;
  sample_t           quot_next;
  logic [VSUM_W-1:0] acc;
  logic              at_end;

  assign acc    = VSUM_W'(rem) + VSUM_W'(step.sample);
  assign at_end = (window_count == CNT_W'(WINDOW - 1));

  generate
    if (WINDOW >= 256) begin : g_wide
      logic carry;
      assign carry     = (acc >= VSUM_W'(WINDOW));
      assign rem_next  = carry ? CNT_W'(acc - VSUM_W'(WINDOW)) : CNT_W'(acc);
      assign quot_next = quot + SAMPLE_W'(carry);
    end else begin : g_narrow
      logic [PROD_W-1:0] prod;
      logic [VSUM_W-1:0] qinc;
      assign prod      = PROD_W'(acc) * PROD_W'(RECIP_M);
      assign qinc      = VSUM_W'(prod >> RECIP_S);
      assign rem_next  = CNT_W'(acc - VSUM_W'(qinc * VSUM_W'(WINDOW)));
      assign quot_next = quot + SAMPLE_W'(qinc);
    end
  endgenerate

  assign window_count_next = window_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      rem          <= '0;
      quot         <= '0;
      dc_offset    <= OFFSET_RESET;
    end else if (step.en) begin
      if (at_end) begin
        window_count <= '0;
        rem          <= '0;
        quot         <= '0;
        dc_offset    <= quot_next;
      end else begin
        window_count <= window_count_next;
        rem          <= rem_next;
        quot         <= quot_next;
      end
    end
  end

  `DCRSC_ASSERT_NOW(a_rem_in_range, 1'b1, rem < WINDOW, "Remainder reached the window length.")
  `DCRSC_ASSERT_NEXT(a_count_wraps, step.en && at_end, window_count == '0, "Count did not wrap.")
  `DCRSC_ASSERT_NEXT(a_offset_held, !(step.en && at_end), $stable(dc_offset), "Offset moved early.")

endmodule

`default_nettype wire

### design/dcrsc_smoother.sv
`default_nettype none

`include "dc_remove_smooth_clip_unit_assert.svh"

module dcrsc_smoother (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dcrsc_pkg::step_t   step,
  input  wire dcrsc_pkg::sample_t dc_offset,
  output dcrsc_pkg::audio_t       audio_new
);
  import dcrsc_pkg::*;

  state_t                     state;
  state_t                     state_next;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    scaled;
  logic signed [WHOLE_W-1:0]  whole;
  logic signed [WHOLE_W-1:0]  whole_tz;

  assign diff = $signed(DIFF_W'(step.sample) - DIFF_W'(dc_offset));

  // New state is (x * 2^16 + 7 * old + 4) / 8 rounded down.
  assign sum = (SUM_W'(diff) <<< FRAC_W) + (SUM_W'(state) <<< 3) - SUM_W'(state)
               + SUM_W'(ROUND_HALF);
  assign scaled = sum >>> 3;

  always_comb begin
    if (scaled > SUM_W'(STATE_BOUND)) begin
      state_next = STATE_W'(STATE_BOUND);
    end else if (scaled < -SUM_W'(STATE_BOUND)) begin
      state_next = -STATE_W'(STATE_BOUND);
    end else begin
      state_next = STATE_W'(scaled);
    end
  end

  // The whole part is rounded toward zero before it is saturated.
  assign whole    = state_next[STATE_W-1:FRAC_W];
  assign whole_tz = whole + WHOLE_W'(state_next[STATE_W-1] && (|state_next[FRAC_W-1:0]));

  always_comb begin
    if (whole_tz > WHOLE_W'(AUDIO_MAX)) begin
      audio_new = SAMPLE_W'(AUDIO_MAX);
    end else if (whole_tz < WHOLE_W'(AUDIO_MIN)) begin
      audio_new = SAMPLE_W'(AUDIO_MIN);
    end else begin
      audio_new = SAMPLE_W'(whole_tz);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step.en) begin
      state <= state_next;
    end
  end

  `DCRSC_ASSERT_NOW(a_state_bounded, 1'b1,
    (state <= STATE_BOUND) && (state >= -STATE_BOUND), "Filter state out of range.")
  `DCRSC_ASSERT_NEXT(a_state_held, !step.en, $stable(state), "Filter state moved while idle.")

endmodule

`default_nettype wire

### design/dc_remove_smooth_clip_unit.sv
// Removes the DC offset from unsigned 8-bit converter samples, smooths them with a one-pole
// low-pass filter (one eighth of the new difference plus seven eighths of the previous state,
// 16 fraction bits) and gives signed 8-bit samples saturated to -128..127. The offset starts
// at 128 and is replaced by the mean of each completed window of WINDOW samples; the new
// offset applies from the following sample. One request is taken per clock cycle while the output
// side is not stalled: the filter state and the window accumulator are each updated as a request
// moves from the input register to the result register, which then holds the result. No clearing
// pass is needed after reset.
`default_nettype none

module dc_remove_smooth_clip_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               adc_valid,
  output logic                    adc_ready,
  input  wire dcrsc_pkg::sample_t adc_sample,
  output logic                    audio_valid,
  input  wire logic               audio_ready,
  output dcrsc_pkg::audio_t       audio_out
);
  import dcrsc_pkg::*;

  logic    hold_valid;
  sample_t hold_sample;
  logic    advance;
  step_t   step;
  sample_t dc_offset;
  audio_t  audio_new;

  assign advance     = hold_valid && (!audio_valid || audio_ready);
  assign adc_ready   = !hold_valid || advance;
  assign step.en     = advance;
  assign step.sample = hold_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (adc_ready) begin
      hold_valid <= adc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adc_valid && adc_ready) begin
      hold_sample <= adc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      audio_valid <= 1'b0;
    end else if (advance) begin
      audio_valid <= 1'b1;
    end else if (audio_ready) begin
      audio_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      audio_out <= audio_new;
    end
  end

  dcrsc_offset_track u_offset (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .dc_offset (dc_offset)
  );

  dcrsc_smoother u_smoother (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .dc_offset (dc_offset),
    .audio_new (audio_new)
  );

endmodule

`default_nettype wire
